// ===== sv/flptw_pkg.sv =====
// Shared types and constants for the four-level page table walker.
package flptw_pkg;

  localparam int unsigned TableSlotsDefault = 64;
  localparam int unsigned EntryW = 52;
  localparam int unsigned IdxW = 9;

  typedef enum logic [1:0] {
    FN_XLATE = 2'd0,
    FN_MAP   = 2'd1,
    FN_UNMAP = 2'd2,
    FN_BAD   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_MAP   = 3'd1,
    ST_NO_FREE   = 3'd2,
    ST_HUGE      = 3'd3,
    ST_ALREADY   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    FS_CLEAR,
    FS_IDLE,
    FS_READ,
    FS_EVAL,
    FS_LINK,
    FS_DONE
  } fsm_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [47:0] virt_addr;
    logic [51:0] phys_addr;
    logic [11:0] map_flags;
  } req_t;

  typedef struct packed {
    logic [51:0] phys_out;
    logic [2:0]  status;
  } rsp_t;

endpackage

// ===== sv/four_level_page_table_walker.sv =====
// Top level of the four-level page table walker.
//
// Input channel in_*: one request beat (func, virt_addr, phys_addr, map_flags)
// per in_valid & !in_stall. Result channel out_*: one beat (phys_out, status)
// per request, in request order. cfg_wr_en/cfg_wr_data write table_base;
// write it only while the block is idle.
// One request is in flight at a time. Each level takes a read step and an
// evaluate step (FS_READ, FS_EVAL) on the single table store read port.
// Each table allocated by a map adds a clearing sweep over its 512 entries
// and a link step. The result sits in an output register; the next request
// is accepted once the current result has moved into that register.
// After reset all TABLE_SLOTS*512 entries of the store are swept clear with
// in_stall high. While out_stall is high the result holds and the walker
// waits with in_stall high after finishing the next request.
module four_level_page_table_walker import flptw_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = TableSlotsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  req_t        in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output rsp_t        out_data,
  input  logic        cfg_wr_en,
  input  logic [51:0] cfg_wr_data
);

  localparam int unsigned AddrW = $clog2(TABLE_SLOTS) + IdxW;

  logic [51:0]       base_r;
  logic              out_valid_r;
  rsp_t              out_data_r;
  logic              res_valid, res_take;
  rsp_t              res;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr, mem_raddr;
  logic [EntryW-1:0] mem_wdata, mem_rdata;

  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        base_r <= cfg_wr_data;
      end
      if (res_take) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (res_take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  flptw_ctrl #(.TABLE_SLOTS(TABLE_SLOTS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .base      (base_r),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  flptw_mem #(.TABLE_SLOTS(TABLE_SLOTS)) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

endmodule

// ===== sv/flptw_mem.sv =====
// Table store: single write port, single registered read port.
module flptw_mem import flptw_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = TableSlotsDefault,
  localparam int unsigned AddrW = $clog2(TABLE_SLOTS) + IdxW,
  localparam int unsigned Depth = TABLE_SLOTS * (2 ** IdxW)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AddrW-1:0]  wr_addr,
  input  logic [EntryW-1:0] wr_data,
  input  logic [AddrW-1:0]  rd_addr,
  output logic [EntryW-1:0] rd_data
);

  logic [EntryW-1:0] mem_r [Depth];
  logic [EntryW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/flptw_ctrl.sv =====
// Walk sequencer: clearing sweeps, level reads, allocation and leaf updates.
module flptw_ctrl import flptw_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = TableSlotsDefault,
  localparam int unsigned SlotW = $clog2(TABLE_SLOTS),
  localparam int unsigned AddrW = SlotW + IdxW,
  localparam int unsigned CntW = $clog2(TABLE_SLOTS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  req_t              in_data,
  input  logic [51:0]       base,
  output logic              res_valid,
  input  logic              res_take,
  output rsp_t              res,
  output logic              mem_we,
  output logic [AddrW-1:0]  mem_waddr,
  output logic [EntryW-1:0] mem_wdata,
  output logic [AddrW-1:0]  mem_raddr,
  input  logic [EntryW-1:0] mem_rdata
);

  fsm_t             state_r, state_nxt;
  req_t             req_r, req_nxt;
  logic [1:0]       lvl_r, lvl_nxt;
  logic [SlotW-1:0] slot_r, slot_nxt;
  logic [SlotW-1:0] new_slot_r, new_slot_nxt;
  logic [CntW-1:0]  next_free_r, next_free_nxt;
  logic [AddrW-1:0] clr_addr_r, clr_addr_nxt;
  logic [AddrW-1:0] clr_end_r, clr_end_nxt;
  logic             clr_boot_r, clr_boot_nxt;
  rsp_t             res_r, res_nxt;

  logic [IdxW-1:0]  idx;
  logic [AddrW-1:0] entry_addr;
  logic             present, huge;
  logic [39:0]      rel;
  logic             rel_ok;
  logic             last_lvl;
  logic             full;

  always_comb begin
    unique case (lvl_r)
      2'd0: idx = req_r.virt_addr[47:39];
      2'd1: idx = req_r.virt_addr[38:30];
      2'd2: idx = req_r.virt_addr[29:21];
      default: idx = req_r.virt_addr[20:12];
    endcase
  end

  assign entry_addr = {slot_r, idx};
  assign present    = mem_rdata[0];
  assign huge       = mem_rdata[7];
  assign rel        = mem_rdata[51:12] - base[51:12];
  assign rel_ok     = rel < 40'(TABLE_SLOTS);
  assign last_lvl   = (lvl_r == 2'd3);
  assign full       = next_free_r >= CntW'(TABLE_SLOTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FS_CLEAR;
      next_free_r <= CntW'(1);
      clr_addr_r  <= '0;
      clr_end_r   <= AddrW'(TABLE_SLOTS * (2 ** IdxW) - 1);
      clr_boot_r  <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      next_free_r <= next_free_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_end_r   <= clr_end_nxt;
      clr_boot_r  <= clr_boot_nxt;
    end
    req_r      <= req_nxt;
    lvl_r      <= lvl_nxt;
    slot_r     <= slot_nxt;
    new_slot_r <= new_slot_nxt;
    res_r      <= res_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    lvl_nxt       = lvl_r;
    slot_nxt      = slot_r;
    new_slot_nxt  = new_slot_r;
    next_free_nxt = next_free_r;
    clr_addr_nxt  = clr_addr_r;
    clr_end_nxt   = clr_end_r;
    clr_boot_nxt  = clr_boot_r;
    res_nxt       = res_r;
    in_stall      = 1'b1;
    res_valid     = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = entry_addr;
    mem_wdata     = '0;
    mem_raddr     = entry_addr;

    unique case (state_r)
      FS_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + AddrW'(1);
        if (clr_addr_r == clr_end_r) begin
          clr_boot_nxt = 1'b0;
          state_nxt    = clr_boot_r ? FS_IDLE : FS_LINK;
        end
      end
      FS_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          req_nxt   = in_data;
          lvl_nxt   = 2'd0;
          slot_nxt  = '0;
          state_nxt = FS_READ;
        end
      end
      FS_READ: begin
        state_nxt = FS_EVAL;
      end
      FS_EVAL: begin
        res_nxt   = '{phys_out: '0, status: ST_NOT_MAP};
        state_nxt = FS_DONE;
        priority if (req_r.func == FN_BAD) begin
          res_nxt.status = ST_NOT_MAP;
        end else if (req_r.func == FN_MAP) begin
          if (last_lvl) begin
            if (present) begin
              res_nxt.status = ST_ALREADY;
            end else begin
              mem_we         = 1'b1;
              mem_wdata      = req_r.phys_addr | 52'(req_r.map_flags) | 52'd3;
              res_nxt.status = ST_OK;
            end
          end else if (!present) begin
            if (full) begin
              res_nxt.status = ST_NO_FREE;
            end else begin
              new_slot_nxt  = next_free_r[SlotW-1:0];
              next_free_nxt = next_free_r + CntW'(1);
              clr_addr_nxt  = {next_free_r[SlotW-1:0], {IdxW{1'b0}}};
              clr_end_nxt   = {next_free_r[SlotW-1:0], {IdxW{1'b1}}};
              state_nxt     = FS_CLEAR;
            end
          end else if (lvl_r == 2'd2 && huge) begin
            res_nxt.status = ST_HUGE;
          end else if (!rel_ok) begin
            res_nxt.status = ST_NOT_MAP;
          end else begin
            slot_nxt  = rel[SlotW-1:0];
            lvl_nxt   = lvl_r + 2'd1;
            state_nxt = FS_READ;
          end
        end else begin
          if (!present) begin
            res_nxt.status = ST_NOT_MAP;
          end else if (last_lvl || (lvl_r == 2'd2 && huge)) begin
            res_nxt.status = ST_OK;
            if (req_r.func == FN_UNMAP) begin
              mem_we    = 1'b1;
              mem_wdata = mem_rdata & ~52'd1;
            end else if (last_lvl) begin
              res_nxt.phys_out = {mem_rdata[51:12], req_r.virt_addr[11:0]};
            end else begin
              res_nxt.phys_out = {mem_rdata[51:12], 12'd0} |
                                 {31'd0, req_r.virt_addr[20:0]};
            end
          end else if (!rel_ok) begin
            res_nxt.status = ST_NOT_MAP;
          end else begin
            slot_nxt  = rel[SlotW-1:0];
            lvl_nxt   = lvl_r + 2'd1;
            state_nxt = FS_READ;
          end
        end
      end
      FS_LINK: begin
        mem_we    = 1'b1;
        mem_wdata = {base[51:12] + 40'(new_slot_r), 12'h003};
        slot_nxt  = new_slot_r;
        lvl_nxt   = lvl_r + 2'd1;
        state_nxt = FS_READ;
      end
      FS_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = FS_IDLE;
        end
      end
      default: begin
        state_nxt = FS_IDLE;
      end
    endcase
  end

  assign res = res_r;

endmodule

// ===== dv/four_level_page_table_walker_checker.sv =====
// Checker for the page table walker: predicts the result of each request and compares.
module four_level_page_table_walker_checker import flptw_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = TableSlotsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  req_t        in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  rsp_t        out_data,
  input  logic        cfg_wr_en,
  input  logic [51:0] cfg_wr_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] FrameMask = 64'h000F_FFFF_FFFF_F000;

  logic [63:0] pt_mem [TABLE_SLOTS*512];
  int unsigned free_slot;
  logic [51:0] base_reg;
  rsp_t rsp_q[$];

  assign pending = rsp_q.size();

  function automatic int slot_from_entry(logic [63:0] e);
    logic [51:0] rel;
    rel = e[51:0] - {base_reg[51:12], 12'd0};
    if (rel[51:12] >= TABLE_SLOTS) return -1;
    return int'(rel[51:12]);
  endfunction

  function automatic int grab_table();
    int s;
    if (free_slot >= TABLE_SLOTS) return -1;
    s = free_slot;
    free_slot++;
    for (int i = 0; i < 512; i++) pt_mem[s*512+i] = '0;
    return s;
  endfunction

  function automatic rsp_t walk_request(req_t r);
    rsp_t res;
    logic [8:0] idx [4];
    int slot, s, a;
    bit ok;
    logic [63:0] e;
    res.phys_out = '0;
    res.status = ST_NOT_MAP;
    slot = 0;
    for (int l = 0; l < 4; l++) idx[l] = r.virt_addr[47-9*l -: 9];
    if (r.func == FN_XLATE || r.func == FN_UNMAP) begin
      ok = 1;
      for (int l = 0; l < 3 && ok; l++) begin
        a = slot*512 + idx[l];
        e = pt_mem[a];
        if (!e[0]) begin
          ok = 0;
        end else if (l == 2 && e[7]) begin
          if (r.func == FN_XLATE)
            res.phys_out = (e[51:0] & FrameMask[51:0]) | {31'd0, r.virt_addr[20:0]};
          else pt_mem[a][0] = 1'b0;
          res.status = ST_OK;
          ok = 0;
        end else begin
          s = slot_from_entry(e);
          if (s < 0) ok = 0;
          else slot = s;
        end
      end
      if (ok) begin
        a = slot*512 + idx[3];
        e = pt_mem[a];
        if (e[0]) begin
          if (r.func == FN_XLATE) res.phys_out = {e[51:12], r.virt_addr[11:0]};
          else pt_mem[a][0] = 1'b0;
          res.status = ST_OK;
        end
      end
    end else if (r.func == FN_MAP) begin
      res.status = ST_OK;
      for (int l = 0; l < 3; l++) begin
        a = slot*512 + idx[l];
        e = pt_mem[a];
        if (!e[0]) begin
          s = grab_table();
          if (s < 0) begin
            res.status = ST_NO_FREE;
            break;
          end
          pt_mem[a] = ((({12'd0, base_reg} & FrameMask) + (64'(s) << 12)) & FrameMask) | 64'h3;
          slot = s;
        end else begin
          if (l == 2 && e[7]) begin
            res.status = ST_HUGE;
            break;
          end
          s = slot_from_entry(e);
          if (s < 0) begin
            res.status = ST_NOT_MAP;
            break;
          end
          slot = s;
        end
      end
      if (res.status == ST_OK) begin
        a = slot*512 + idx[3];
        if (pt_mem[a][0]) res.status = ST_ALREADY;
        else pt_mem[a] = {12'd0, r.phys_addr} | 64'h3 | {52'd0, r.map_flags};
      end
    end
    if (res.status != ST_OK) res.phys_out = '0;
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_SLOTS*512; i++) pt_mem[i] = '0;
      free_slot = 1;
      base_reg = '0;
      fail_count = 0;
      rsp_q = {};
    end else begin
      if (cfg_wr_en) base_reg = cfg_wr_data;
      if (in_valid && !in_stall) rsp_q.push_back(walk_request(in_data));
      if (out_valid && !out_stall) begin
        got = out_data;
        if (rsp_q.size() == 0) begin
          $display("%0t: unexpected beat phys_out=%h status=%0d", $time,
                   got.phys_out, got.status);
          fail_count++;
        end else begin
          want = rsp_q.pop_front();
          if (got.phys_out !== want.phys_out)
            $display("%0t: phys_out expected %h actual %h", $time,
                     want.phys_out, got.phys_out);
          if (got.status !== want.status)
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, got.status);
          if (got !== want) fail_count++;
        end
      end
    end
  end
endmodule

// ===== dv/four_level_page_table_walker_tb.sv =====
// Testbench top for the page table walker: stimulus, configuration and verdict.
module four_level_page_table_walker_tb;
  import flptw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Slots = TableSlotsDefault;
  localparam longint CycleLimit = 3_000_000;

  logic clk, rst_n, in_valid, in_stall, out_valid, out_stall, cfg_wr_en;
  req_t in_data;
  rsp_t out_data;
  logic [51:0] cfg_wr_data;
  int fail_count, pending;
  longint cycles;
  bit can_send;
  int gap_left, burst_left;
  logic [47:0] used_va [$];

  four_level_page_table_walker #(.TABLE_SLOTS(Slots)) u_top (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_wr_en, .cfg_wr_data
  );

  four_level_page_table_walker_checker #(.TABLE_SLOTS(Slots)) u_chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_wr_en, .cfg_wr_data, .fail_count, .pending
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // receiver stall pattern: alternating calm and busy phases
  initial begin
    int phase;
    out_stall = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      phase = (phase + 1) % 600;
      out_stall <= (phase < 300) ? 1'b0 : ($urandom_range(0, 3) == 0);
    end
  end

  task automatic send(input logic [1:0] f, input logic [47:0] va, input logic [51:0] pa,
                      input logic [11:0] fl);
    while (can_send && gap_left > 0) begin
      gap_left--;
      @(posedge clk);
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= '{func: f, virt_addr: va, phys_addr: pa, map_flags: fl};
    do @(posedge clk); while (in_stall);
    used_va.push_back(va);
    if (burst_left == 0 || gap_left > 0) begin
      in_valid <= 1'b0;
      if (gap_left == 0) gap_left = 1;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (Slots * 520 + 50) @(posedge clk);
  endtask

  task automatic write_base(input logic [51:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [47:0] pick_va();
    logic [47:0] v;
    if (used_va.size() > 0 && $urandom_range(0, 2) != 0) begin
      v = used_va[$urandom_range(0, used_va.size() - 1)];
      case ($urandom_range(0, 3))
        0: v[11:0] = 12'($urandom);
        1: v[20:12] = 9'($urandom_range(0, 3));
        2: v[29:21] = 9'($urandom_range(0, 3));
        default: ;
      endcase
      return v;
    end
    v = 48'({$urandom, $urandom});
    if ($urandom_range(0, 1)) v[47:30] = 18'($urandom_range(0, 3));
    return v;
  endfunction

  task automatic random_run(input int n);
    logic [1:0] f;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      f = (r < 40) ? FN_MAP : (r < 80) ? FN_XLATE : (r < 97) ? FN_UNMAP : FN_BAD;
      send(f, pick_va(), 52'({$urandom, $urandom}), 12'($urandom));
    end
  endtask

  initial begin
    logic [47:0] v;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_wr_en = 0;
    cfg_wr_data = '0;
    can_send = 1;
    gap_left = 0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    write_base(52'h0_0000_0000_0000);
    send(FN_XLATE, 48'h0, '0, '0);
    send(FN_MAP, 48'h0, 52'hF_FFFF_FFFF_F000, 12'hFFF);
    send(FN_XLATE, 48'h0_0000_0000_0FFF, '0, '0);
    send(FN_MAP, 48'h0, 52'h1000, 12'h0);
    send(FN_MAP, 48'hFFFF_FFFF_FFFF, 52'h000_0000_0000, 12'h000);
    send(FN_XLATE, 48'hFFFF_FFFF_FFFF, '0, '0);
    send(FN_UNMAP, 48'hFFFF_FFFF_FFFF, '0, '0);
    send(FN_UNMAP, 48'hFFFF_FFFF_FFFF, '0, '0);
    send(FN_XLATE, 48'hFFFF_FFFF_FFFF, '0, '0);
    send(FN_BAD, 48'h0, 52'h5000, 12'h5);
    send(FN_XLATE, 48'h0, '0, '0);
    // map a leaf, then map the same address again with flags that carry the huge bit
    send(FN_MAP, 48'h0000_4000_0000, 52'h0, '0);
    send(FN_XLATE, 48'h0000_4000_0000, '0, '0);
    send(FN_MAP, 48'h0000_4000_0000, 52'hA_BC00_0000, 12'h080);
    send(FN_XLATE, 48'h0000_4012_3456, '0, '0);
    send(FN_UNMAP, 48'h0000_4000_0000, '0, '0);
    drain();
    // base at the top of the address range: map level-3 table slot as a leaf, then walk past it
    write_base(52'hF_FFFF_FFFF_FFFF);
    send(FN_XLATE, 48'h0, '0, '0);
    send(FN_MAP, 48'h0000_0000_1000, 52'h2000, 12'h3);
    send(FN_UNMAP, 48'h0, '0, '0);
    drain();
    write_base(52'h0);
    // fill toward exhaustion with distinct upper indexes
    for (int i = 0; i < 30; i++) begin
      v = {9'(i + 1), 9'(i), 9'(i), 9'd0, 12'd0};
      send(FN_MAP, v, 52'({$urandom, $urandom}), 12'($urandom));
    end
    random_run(200);
    drain();
    // send without the idle gaps between requests
    can_send = 0;
    write_base(52'({$urandom, $urandom}));
    random_run(150);
    drain();
    write_base(52'h0);
    can_send = 1;
    random_run(500);
    drain();
    write_base({$urandom, 20'h0});
    random_run(300);
    drain();
    write_base(52'h0);
    random_run(350);
    drain();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
